FILE: rtl/rxht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rxht_pkg
// Shared types, constants and channel table helpers for the receive hop tracker.
// ----------------------------------------------------------------------------
package rxht_pkg;

  // Channel table size and index width
  localparam int CHANNEL_COUNT = 16;
  localparam int IDX_W         = $clog2(CHANNEL_COUNT);

  localparam int TIMER_W  = 16;
  localparam int PERIOD_W = 8;
  localparam int DWELL_W  = 10;
  localparam int CHAN_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] POLL_PERIOD_RST  = PERIOD_W'(5);
  localparam logic [DWELL_W-1:0]  FIRST_DWELL_RST  = DWELL_W'(50);
  localparam logic [DWELL_W-1:0]  SECOND_DWELL_RST = DWELL_W'(100);

  // Channel table pattern, repeated over the table
  localparam logic [CHAN_W-1:0] CHAN_0 = CHAN_W'(48);
  localparam logic [CHAN_W-1:0] CHAN_1 = CHAN_W'(72);
  localparam logic [CHAN_W-1:0] CHAN_2 = CHAN_W'(64);
  localparam logic [CHAN_W-1:0] CHAN_3 = CHAN_W'(56);

  // Item kinds
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_POLL = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_POLL_PERIOD = 2'd0,
    CFG_FIRST_DWELL    = 2'd1,
    CFG_SECOND_DWELL   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] rx_poll_period;
    logic [DWELL_W-1:0]  first_dwell;
    logic [DWELL_W-1:0]  second_dwell;
  } cfg_t;

  typedef struct packed {
    cmd_t command;
    logic rx_data_ready;
    logic frame_complete;
  } item_t;

  typedef struct packed {
    logic              serviced;
    logic              channel_write;
    logic [CHAN_W-1:0] radio_channel;
    logic              package_received;
  } result_t;

  // Table entry at an index
  function automatic logic [CHAN_W-1:0] chan_at(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0]      wide;
    logic [CHAN_W-1:0]   ch;
    wide = {1'b0, idx};
    case (wide[1:0])
      2'd0:    ch = CHAN_0;
      2'd1:    ch = CHAN_1;
      2'd2:    ch = CHAN_2;
      default: ch = CHAN_3;
    endcase
    return ch;
  endfunction

  // Advance an index by one or two, wrapping over the table
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                input logic [1:0]       step);
    logic [IDX_W+1:0] sum;
    sum = {2'b00, idx} + {{IDX_W{1'b0}}, step};
    if (sum >= (IDX_W+2)'(CHANNEL_COUNT)) begin
      sum = sum - (IDX_W+2)'(CHANNEL_COUNT);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rxht_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rxht_cfg_regs
// Configuration register file: poll period and the two dwell limits.
// ----------------------------------------------------------------------------
module rxht_cfg_regs (
  input  wire  logic                             clk,
  input  wire  logic                             rst,
  input  wire  logic                             cfg_valid,
  output logic                                   cfg_ready,
  input  wire  logic [rxht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  logic [rxht_pkg::CFG_DATA_W-1:0]  cfg_data,
  output rxht_pkg::cfg_t                         cfg
);

  assign cfg_ready = 1'b1;

  // Write the addressed register; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rx_poll_period <= rxht_pkg::POLL_PERIOD_RST;
      cfg.first_dwell    <= rxht_pkg::FIRST_DWELL_RST;
      cfg.second_dwell   <= rxht_pkg::SECOND_DWELL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rxht_pkg::CFG_RX_POLL_PERIOD: begin
          cfg.rx_poll_period <= cfg_data[rxht_pkg::PERIOD_W-1:0];
        end
        rxht_pkg::CFG_FIRST_DWELL: begin
          cfg.first_dwell <= cfg_data[rxht_pkg::DWELL_W-1:0];
        end
        rxht_pkg::CFG_SECOND_DWELL: begin
          cfg.second_dwell <= cfg_data[rxht_pkg::DWELL_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rxht_hop_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rxht_hop_core
// Tracker state and the update for one tick or poll item.
// ----------------------------------------------------------------------------
module rxht_hop_core (
  input  wire  logic      clk,
  input  wire  logic      rst,
  input  wire  logic      fire,
  input  wire  rxht_pkg::item_t item,
  input  wire  rxht_pkg::cfg_t  cfg,
  output rxht_pkg::result_t result
);

  logic [rxht_pkg::TIMER_W-1:0] poll_timer, poll_timer_next;
  logic [rxht_pkg::TIMER_W-1:0] hop_timer, hop_timer_next;
  logic                         period_armed, period_armed_next;
  logic [rxht_pkg::IDX_W-1:0]   table_index, table_index_next;
  logic [rxht_pkg::CHAN_W-1:0]  current_channel, current_channel_next;
  logic [rxht_pkg::CHAN_W-1:0]  effective_channel, effective_channel_next;
  logic [rxht_pkg::CHAN_W-1:0]  next_channel, next_channel_next;
  logic [rxht_pkg::CHAN_W-1:0]  after_next_channel, after_next_channel_next;
  logic                         alternate_flag, alternate_flag_next;

  logic [rxht_pkg::PERIOD_W-1:0] threshold;
  logic [rxht_pkg::IDX_W-1:0]    idx_plus1, idx_plus2;
  logic [rxht_pkg::CHAN_W-1:0]   chan_plus1, chan_plus2, chan_sel;

  assign threshold  = period_armed ? cfg.rx_poll_period : '0;
  assign idx_plus1  = rxht_pkg::wrap_add(table_index, 2'd1);
  assign idx_plus2  = rxht_pkg::wrap_add(table_index, 2'd2);
  assign chan_plus1 = rxht_pkg::chan_at(idx_plus1);
  assign chan_plus2 = rxht_pkg::chan_at(idx_plus2);

  // Work out the result and next state for the item at hand
  always_comb begin
    poll_timer_next         = poll_timer;
    hop_timer_next          = hop_timer;
    period_armed_next       = period_armed;
    table_index_next        = table_index;
    current_channel_next    = current_channel;
    effective_channel_next  = effective_channel;
    next_channel_next       = next_channel;
    after_next_channel_next = after_next_channel;
    alternate_flag_next     = alternate_flag;
    chan_sel                = '0;
    result                  = '0;

    if (item.command == rxht_pkg::CMD_TICK) begin
      // Saturating timers
      if (poll_timer != rxht_pkg::TIMER_MAX) poll_timer_next = poll_timer + 1'b1;
      if (hop_timer != rxht_pkg::TIMER_MAX)  hop_timer_next  = hop_timer + 1'b1;
    end else if (poll_timer >= {{(rxht_pkg::TIMER_W-rxht_pkg::PERIOD_W){1'b0}}, threshold}) begin
      poll_timer_next   = '0;
      period_armed_next = 1'b1;
      result.serviced   = 1'b1;
      if (item.rx_data_ready) begin
        // Packet caught: realign to the channel it came in on
        hop_timer_next      = '0;
        alternate_flag_next = 1'b0;
        if (current_channel != rxht_pkg::chan_at(table_index)) begin
          if (current_channel == next_channel) begin
            table_index_next = idx_plus1;
          end else if (current_channel == after_next_channel) begin
            table_index_next = idx_plus2;
          end
        end
        effective_channel_next  = current_channel;
        result.package_received = item.frame_complete;
      end else begin
        // No packet: pick the channel to listen on
        next_channel_next       = chan_plus1;
        after_next_channel_next = chan_plus2;
        if (hop_timer < {{(rxht_pkg::TIMER_W-rxht_pkg::DWELL_W){1'b0}}, cfg.first_dwell}) begin
          chan_sel = alternate_flag ? chan_plus1 : effective_channel;
        end else if (hop_timer <
                     {{(rxht_pkg::TIMER_W-rxht_pkg::DWELL_W){1'b0}}, cfg.second_dwell}) begin
          chan_sel = alternate_flag ? chan_plus2 : chan_plus1;
        end else begin
          hop_timer_next   = {{(rxht_pkg::TIMER_W-rxht_pkg::DWELL_W){1'b0}}, cfg.second_dwell};
          table_index_next = idx_plus1;
          chan_sel         = chan_plus1;
        end
        current_channel_next = chan_sel;
        alternate_flag_next  = !alternate_flag;
        result.channel_write = 1'b1;
        result.radio_channel = chan_sel;
      end
    end
  end

  // Hold state; advance only when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_timer         <= '0;
      hop_timer          <= '0;
      period_armed       <= 1'b0;
      table_index        <= '0;
      current_channel    <= '0;
      effective_channel  <= '0;
      next_channel       <= '0;
      after_next_channel <= '0;
      alternate_flag     <= 1'b0;
    end else if (fire) begin
      poll_timer         <= poll_timer_next;
      hop_timer          <= hop_timer_next;
      period_armed       <= period_armed_next;
      table_index        <= table_index_next;
      current_channel    <= current_channel_next;
      effective_channel  <= effective_channel_next;
      next_channel       <= next_channel_next;
      after_next_channel <= after_next_channel_next;
      alternate_flag     <= alternate_flag_next;
    end
  end

  // A serviced poll restarts the poll timer
  a_poll_restart: assert property (@(posedge clk) disable iff (rst)
    fire && result.serviced |=> poll_timer == '0 && period_armed)
    else $error("poll timer not restarted after serviced poll");

  // A package report never comes with a channel write
  a_pkg_no_write: assert property (@(posedge clk) disable iff (rst)
    result.package_received |-> result.serviced && !result.channel_write)
    else $error("package report with channel write");

  // Table index stays inside the table
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, table_index} < (rxht_pkg::IDX_W+1)'(rxht_pkg::CHANNEL_COUNT))
    else $error("table index out of range");

  // A channel write records the programmed channel and flips the alternate flag
  a_write_track: assert property (@(posedge clk) disable iff (rst)
    fire && result.channel_write |=>
      current_channel == $past(result.radio_channel) &&
      alternate_flag != $past(alternate_flag))
    else $error("channel write not tracked");

  // State holds while no item is processed
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(hop_timer) && $stable(table_index))
    else $error("state changed without an item");

endmodule
`default_nettype wire

FILE: rtl/rx_channel_hop_tracker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rx_channel_hop_tracker_unit
// Receive-side hop tracker: millisecond ticks and receive polls in, one
// result item per input item out.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Payload
//  s_*      in   s_tvalid/s_tready    tuser: command; tdata: data flags
//  m_*      out  m_tvalid/m_tready    tdata: serviced, write, channel, package
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item per cycle sustained while the output is not stalled (input
//  register, then the update in rxht_hop_core into the result register).
//  Reset (rst, synchronous) empties both registers and restores state and
//  configuration defaults. A stalled output stops the update stage; the input
//  register still takes one item while the result waits.
// ----------------------------------------------------------------------------
module rx_channel_hop_tracker_unit (
  input  wire  logic                             clk,
  input  wire  logic                             rst,
  // bit 0: command
  input  wire  logic                             s_tuser,
  // bit 0: rx_data_ready, bit 1: frame_complete, bits 7:2: zero
  input  wire  logic [7:0]                       s_tdata,
  input  wire  logic                             s_tvalid,
  output logic                                   s_tready,
  // bit 0: serviced, bit 1: channel_write, bits 8:2: radio_channel,
  // bit 9: package_received, bits 15:10: zero
  output logic [15:0]                            m_tdata,
  output logic                                   m_tvalid,
  input  wire  logic                             m_tready,
  input  wire  logic                             cfg_valid,
  output logic                                   cfg_ready,
  input  wire  logic [rxht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  logic [rxht_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rxht_pkg::cfg_t    cfg;
  rxht_pkg::item_t   in_item;
  rxht_pkg::result_t result;
  rxht_pkg::result_t out_result;
  logic              in_valid;
  logic              fire;

  rxht_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Process the held item when the result register is free
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command        <= rxht_pkg::cmd_t'(s_tuser);
      in_item.rx_data_ready  <= s_tdata[0];
      in_item.frame_complete <= s_tdata[1];
    end
  end

  rxht_hop_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

  assign m_tdata = {6'b000000, out_result.package_received, out_result.radio_channel,
                    out_result.channel_write, out_result.serviced};

endmodule
`default_nettype wire

FILE: tb/sv/rx_channel_hop_tracker_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_channel_hop_tracker_unit_test
// Self-checking bench for the receive hop tracker. A scoreboard model tracks
// poll and hop timers, table index and channel choice. Every accepted tick or
// poll queues one expected result item, and the monitor checks each output
// item against it field by field. Directed cases cover the first poll, the
// dwell bands, realignment and the largest register values. Random traffic
// with idling, a long output stall and several register settings follows.
// ----------------------------------------------------------------------------
module rx_channel_hop_tracker_unit_test;

  localparam int CLK_HALF_NS = 6;
  localparam int RESET_CYCLES = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TIMEOUT_NS = 3_000_000;
  localparam int PRINT_CAP = 20;
  localparam logic [rxht_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  // Fields of one result item
  typedef struct packed {
    logic                        serviced;
    logic                        chan_write;
    logic [rxht_pkg::CHAN_W-1:0] channel;
    logic                        pkg_rx;
  } hop_result_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tuser;
  logic [7:0]                      s_tdata;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [15:0]                     m_tdata;
  logic                            m_tvalid;
  logic                            m_tready;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [rxht_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rxht_pkg::CFG_DATA_W-1:0] cfg_data;

  // Scoreboard copy of the tracker state and registers
  logic [rxht_pkg::TIMER_W-1:0]  poll_ticks;
  logic [rxht_pkg::TIMER_W-1:0]  hop_ticks;
  logic                          armed;
  logic [rxht_pkg::IDX_W-1:0]    hop_index;
  logic [rxht_pkg::CHAN_W-1:0]   cur_ch;
  logic [rxht_pkg::CHAN_W-1:0]   eff_ch;
  logic [rxht_pkg::CHAN_W-1:0]   nxt_ch;
  logic [rxht_pkg::CHAN_W-1:0]   nxt2_ch;
  logic                          alt;
  logic [rxht_pkg::PERIOD_W-1:0] period_cfg;
  logic [rxht_pkg::DWELL_W-1:0]  dwell1_cfg;
  logic [rxht_pkg::DWELL_W-1:0]  dwell2_cfg;

  hop_result_t expected_hops[$];
  int          error_count;
  int          items_sent;
  int          results_checked;
  int          serviced_count;
  int          write_count;
  int          package_count;
  int          realign_count;
  int          config_count;
  bit          src_idle_on;
  bit          sink_idle_on;
  int          long_hold_cycles;

  rx_channel_hop_tracker_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #(CLK_HALF_NS) clk = ~clk;

  // Channel table entry at an index
  function automatic logic [rxht_pkg::CHAN_W-1:0] table_channel(
      input logic [rxht_pkg::IDX_W-1:0] idx);
    int unsigned k;
    k = (int'(idx) % rxht_pkg::CHANNEL_COUNT) & 3;
    case (k)
      0:       return rxht_pkg::CHAN_0;
      1:       return rxht_pkg::CHAN_1;
      2:       return rxht_pkg::CHAN_2;
      default: return rxht_pkg::CHAN_3;
    endcase
  endfunction

  function automatic logic [rxht_pkg::IDX_W-1:0] step_index(
      input logic [rxht_pkg::IDX_W-1:0] idx, input int unsigned step);
    return rxht_pkg::IDX_W'((int'(idx) + step) % rxht_pkg::CHANNEL_COUNT);
  endfunction

  task automatic reset_tracker_model();
    period_cfg = rxht_pkg::POLL_PERIOD_RST;
    dwell1_cfg = rxht_pkg::FIRST_DWELL_RST;
    dwell2_cfg = rxht_pkg::SECOND_DWELL_RST;
    poll_ticks = '0;
    hop_ticks  = '0;
    armed      = 1'b0;
    hop_index  = '0;
    cur_ch     = '0;
    eff_ch     = '0;
    nxt_ch     = '0;
    nxt2_ch    = '0;
    alt        = 1'b0;
  endtask

  // Advance the tracker state by one item and return the result it gives
  function automatic hop_result_t predict_hop(input rxht_pkg::cmd_t cmd, input logic rdy,
                                              input logic done);
    hop_result_t                   r;
    logic [rxht_pkg::PERIOD_W-1:0] limit;
    logic [rxht_pkg::CHAN_W-1:0]   ch;
    r = '0;
    if (cmd == rxht_pkg::CMD_TICK) begin
      if (poll_ticks != rxht_pkg::TIMER_MAX) poll_ticks = poll_ticks + 1'b1;
      if (hop_ticks != rxht_pkg::TIMER_MAX) hop_ticks = hop_ticks + 1'b1;
      return r;
    end
    // First poll after reset sees a zero period
    limit = armed ? period_cfg : '0;
    if (poll_ticks < rxht_pkg::TIMER_W'(limit)) return r;
    poll_ticks = '0;
    armed = 1'b1;
    r.serviced = 1'b1;
    if (rdy) begin
      hop_ticks = '0;
      alt = 1'b0;
      // Realign when the packet came in on a lookahead channel
      if (cur_ch != table_channel(hop_index)) begin
        if (cur_ch == nxt_ch) begin
          hop_index = step_index(hop_index, 1);
          realign_count++;
        end else if (cur_ch == nxt2_ch) begin
          hop_index = step_index(hop_index, 2);
          realign_count++;
        end
      end
      eff_ch = cur_ch;
      r.pkg_rx = done;
      return r;
    end
    nxt_ch  = table_channel(step_index(hop_index, 1));
    nxt2_ch = table_channel(step_index(hop_index, 2));
    if (hop_ticks < rxht_pkg::TIMER_W'(dwell1_cfg)) begin
      ch = alt ? nxt_ch : eff_ch;
    end else if (hop_ticks < rxht_pkg::TIMER_W'(dwell2_cfg)) begin
      ch = alt ? nxt2_ch : nxt_ch;
    end else begin
      hop_ticks = rxht_pkg::TIMER_W'(dwell2_cfg);
      hop_index = step_index(hop_index, 1);
      ch = table_channel(hop_index);
    end
    cur_ch = ch;
    alt = ~alt;
    r.chan_write = 1'b1;
    r.channel = ch;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
               $realtime, what, got, want, results_checked);
  endtask

  // Offer one item, with an optional idle gap first, and queue its result
  task automatic send_item(input rxht_pkg::cmd_t cmd, input logic rdy, input logic done);
    hop_result_t want;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, done, rdy};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_hop(cmd, rdy, done);
    expected_hops.push_back(want);
    items_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(rxht_pkg::CMD_TICK, 1'($urandom), 1'($urandom));
  endtask

  // Stop offering items and wait until every expected result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_hops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rxht_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rxht_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rxht_pkg::CFG_RX_POLL_PERIOD: period_cfg = value[rxht_pkg::PERIOD_W-1:0];
      rxht_pkg::CFG_FIRST_DWELL:    dwell1_cfg = value[rxht_pkg::DWELL_W-1:0];
      rxht_pkg::CFG_SECOND_DWELL:   dwell2_cfg = value[rxht_pkg::DWELL_W-1:0];
      default:                      ;
    endcase
  endtask

  // Write all registers, plus the unused index, while the block is idle
  task automatic set_config(input logic [rxht_pkg::CFG_DATA_W-1:0] period,
                            input logic [rxht_pkg::CFG_DATA_W-1:0] dwell1,
                            input logic [rxht_pkg::CFG_DATA_W-1:0] dwell2);
    drain_results();
    write_reg(rxht_pkg::CFG_RX_POLL_PERIOD, period);
    write_reg(rxht_pkg::CFG_FIRST_DWELL, dwell1);
    write_reg(rxht_pkg::CFG_SECOND_DWELL, dwell2);
    write_reg(CFG_IDX_UNUSED, rxht_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    config_count++;
  endtask

  // First poll always serviced, then the period gates polls
  task automatic test_first_poll();
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_item(rxht_pkg::CMD_POLL, 1'b1, 1'b1);
    send_ticks(5);
    send_item(rxht_pkg::CMD_POLL, 1'b1, 1'b1);
    send_item(rxht_pkg::CMD_POLL, 1'b1, 1'b0);
  endtask

  // Walk both dwell bands, both realignments and the table step
  task automatic test_hop_bands();
    set_config(10'd0, 10'd2, 10'd4);
    send_item(rxht_pkg::CMD_POLL, 1'b1, 1'b0);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b1);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_ticks(2);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_item(rxht_pkg::CMD_POLL, 1'b1, 1'b0);
    send_ticks(2);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_item(rxht_pkg::CMD_POLL, 1'b1, 1'b1);
    send_ticks(4);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_item(rxht_pkg::CMD_POLL, 1'b1, 1'b1);
  endtask

  // Largest period and dwells; the period write carries bits above its width
  task automatic test_extreme_config();
    set_config(10'h3FF, 10'h3FF, 10'h3FF);
    send_item(rxht_pkg::CMD_POLL, 1'b1, 1'b0);
    send_ticks(254);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_ticks(1);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
    send_item(rxht_pkg::CMD_POLL, 1'b0, 1'b0);
  endtask

  // Mostly tick runs closed by a poll, some noise; optional long output stall
  task automatic run_hop_phase(input int n_items, input bit with_hold);
    int  start;
    bit  held;
    bit  paused;
    int  k;
    start  = items_sent;
    held   = 1'b0;
    paused = 1'b0;
    while (items_sent - start < n_items) begin
      if (with_hold && !held && items_sent - start >= n_items / 3) begin
        long_hold_cycles = 150;
        held = 1'b1;
      end
      if (!paused && items_sent - start >= (3 * n_items) / 4) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, int'(period_cfg) + 3);
        send_ticks(k);
        send_item(rxht_pkg::CMD_POLL, ($urandom_range(0, 3) == 0), 1'($urandom));
      end else begin
        send_item(rxht_pkg::cmd_t'($urandom_range(0, 1)), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    set_config(10'd0, 10'd0, 10'd0);
    run_hop_phase(30, 1'b0);
    set_config(10'd1, 10'd3, 10'd6);
    run_hop_phase(50, 1'b1);
    // Dwells out of order leave the middle band empty
    set_config(10'd2, 10'd6, 10'd2);
    run_hop_phase(30, 1'b0);
    repeat (2) begin
      set_config(rxht_pkg::CFG_DATA_W'($urandom_range(0, 4)),
                 rxht_pkg::CFG_DATA_W'($urandom_range(0, 10)),
                 rxht_pkg::CFG_DATA_W'($urandom_range(0, 14)));
      run_hop_phase(30, 1'b0);
    end
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_config(10'd1, 10'd4, 10'd9);
    run_hop_phase(40, 1'b0);
  endtask

  // Result monitor: compare each output item with the oldest expectation
  always @(posedge clk) begin : check_results
    hop_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_hops.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        want = expected_hops.pop_front();
        if (m_tdata[0] !== want.serviced)
          report_mismatch("serviced", m_tdata[0], want.serviced);
        if (m_tdata[1] !== want.chan_write)
          report_mismatch("channel_write", m_tdata[1], want.chan_write);
        if (m_tdata[8:2] !== want.channel)
          report_mismatch("radio_channel", m_tdata[8:2], want.channel);
        if (m_tdata[9] !== want.pkg_rx)
          report_mismatch("package_received", m_tdata[9], want.pkg_rx);
        serviced_count += want.serviced;
        write_count    += want.chan_write;
        package_count  += want.pkg_rx;
      end
      results_checked++;
    end
  end

  // Output ready: random stalls, plus one long hold when asked
  initial begin : drive_ready
    int n;
    m_tready <= 1'b0;
    forever begin
      if (long_hold_cycles > 0) begin
        n = long_hold_cycles;
        long_hold_cycles = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

  initial begin : run_tests
    int guard;
    error_count = 0;
    items_sent = 0;
    results_checked = 0;
    serviced_count = 0;
    write_count = 0;
    package_count = 0;
    realign_count = 0;
    config_count = 0;
    long_hold_cycles = 0;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    reset_tracker_model();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tuser   <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_first_poll();
    test_hop_bands();
    test_extreme_config();
    test_random_traffic();

    // Let the last results come out, then look for leftovers
    s_tvalid <= 1'b0;
    guard = 0;
    while (expected_hops.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_hops.size() != 0)
      report_mismatch("results never delivered", expected_hops.size(), 0);

    $display("Covered %0d items and %0d results over %0d register settings",
             items_sent, results_checked, config_count);
    $display("Serviced polls %0d, channel writes %0d, packages %0d, realignments %0d",
             serviced_count, write_count, package_count, realign_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: rx_channel_hop_tracker_unit.f
rtl/rxht_pkg.sv
rtl/rxht_cfg_regs.sv
rtl/rxht_hop_core.sv
rtl/rx_channel_hop_tracker_unit.sv
tb/sv/rx_channel_hop_tracker_unit_test.sv
